@@ sv/chm_pkg.sv @@
`default_nettype none
package chm_pkg;

    // default geometry
    localparam int DEF_BUCKETS = 256;
    localparam int DEF_ENTRIES = 1024;

    // action codes
    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_FIND   = 3'd1;
    localparam logic [2:0] ACT_REMOVE = 3'd2;
    localparam logic [2:0] ACT_UPDATE = 3'd3;
    localparam logic [2:0] ACT_SWAP   = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic        [2:0]  action;
        logic        [30:0] key;
        logic        [30:0] second_key;
        logic signed [31:0] value;
        logic signed [31:0] miss_value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic        [1:0]  status;
    } t_rsp;

endpackage
`default_nettype wire

@@ sv/chained_hash_map_core.sv @@
`default_nettype none
// Integer-to-integer hash map with separate chaining over a pool of ENTRIES
// entries and BUCKETS chain heads, both held in synchronous RAMs with
// registered reads. One item is processed at a time; each gives exactly one
// result. After reset the block clears the bucket-head RAM, one bucket per
// cycle, before it takes its first item. Find walks its chain node by node;
// a plain update hit does the same, while remove of a present key and an
// update that inserts pass through further states, insert goes straight to
// allocation, swap walks both chains, and a swap with both keys zero or an
// unused action code goes straight to the result. Taking an entry from the
// free list adds a state that reads its link. When BUCKETS is not a power of
// two the bucket index comes from a reciprocal multiply and one correction
// step, which lengthens every chain lookup (a swap with both keys nonzero
// does two lookups). After the result is loaded the block returns to idle.
// A new item may be accepted while the previous result still waits in the
// output register.
module chained_hash_map_core #(
    parameter int BUCKETS = chm_pkg::DEF_BUCKETS,
    parameter int ENTRIES = chm_pkg::DEF_ENTRIES
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire chm_pkg::t_req i_item,
    output logic               o_valid,
    input  wire                i_ready,
    output chm_pkg::t_rsp      o_item
);

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int AW = $clog2(ENTRIES);
    localparam int IW = $clog2(ENTRIES + 1);
    localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
    localparam logic [IW-1:0] NIL = IW'(ENTRIES);
    localparam logic [BW:0] BK = (BW + 1)'(BUCKETS);
    localparam logic [BW-1:0] BLAST = BW'(BUCKETS - 1);
    localparam logic [30:0] BMASK = 31'(BUCKETS - 1);
    // floor(2^31 / BUCKETS): quotient estimate is exact or one low
    localparam logic [31:0] MREC = 32'((64'd1 << 31) / BUCKETS);

    typedef enum logic [15:0] {
        S_CLR   = 16'h0001,
        S_IDLE  = 16'h0002,
        S_MOD   = 16'h0004,
        S_HRD   = 16'h0008,
        S_HWT   = 16'h0010,
        S_EWT   = 16'h0020,
        S_HIT   = 16'h0040,
        S_MISS  = 16'h0080,
        S_ALLOC = 16'h0100,
        S_FWT   = 16'h0200,
        S_INS   = 16'h0400,
        S_REM1  = 16'h0800,
        S_REM2  = 16'h1000,
        S_SW1   = 16'h2000,
        S_SW2   = 16'h4000,
        S_DONE  = 16'h8000
    } t_state;

    t_state r_state;

    // memories
    logic [IW-1:0] head_mem [BUCKETS];
    logic [30:0]   key_mem  [ENTRIES];
    logic [31:0]   val_mem  [ENTRIES];
    logic [IW-1:0] link_mem [ENTRIES];
    logic [IW-1:0] r_head_q;
    logic [30:0]   r_key_q;
    logic [31:0]   r_val_q;
    logic [IW-1:0] r_link_q;

    // item and walk registers
    logic [2:0]    r_act;
    logic [30:0]   r_key;
    logic [30:0]   r_key2;
    logic [31:0]   r_val;
    logic [31:0]   r_dflt;
    logic [30:0]   r_cur_key;
    logic          r_ph;
    logic [BW-1:0] r_bkt;
    logic [BW:0]   r_rem;
    logic [1:0]    r_mstep;
    logic [30:0]   r_q;
    logic [IW-1:0] r_head;
    logic [IW-1:0] r_cur;
    logic [IW-1:0] r_prev;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_link;
    logic [31:0]   r_fval;
    logic [IW-1:0] r_aidx;
    logic [31:0]   r_aval;
    logic [IW-1:0] r_free;
    logic [IW-1:0] r_nuc;
    logic [31:0]   r_rv;
    logic [1:0]    r_st;
    logic [BW-1:0] r_clr;
    logic          r_ovalid;
    chm_pkg::t_rsp r_out;

    logic [IW-1:0] ent_raddr;
    logic [61:0]   mod_prod;
    logic [BW:0]   mod_lo;
    logic [BW:0]   mod_fix;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_item  = r_out;

    // entry read address: chain head, next link, or free-list head
    always_comb begin
        case (r_state)
            S_HWT:   ent_raddr = r_head_q;
            S_EWT:   ent_raddr = r_link_q;
            default: ent_raddr = r_free;
        endcase
    end

    // remainder by reciprocal: quotient estimate, low bits of key - q*B, fix-up
    assign mod_prod = 62'(r_cur_key) * 62'(MREC);
    assign mod_lo   = r_cur_key[BW:0] - r_q[BW:0] * BK;
    assign mod_fix  = (r_rem >= BK) ? (r_rem - BK) : r_rem;

    // RAM ports
    always_ff @(posedge i_clk) begin
        r_head_q <= head_mem[r_bkt];
        r_key_q  <= key_mem[ent_raddr[AW-1:0]];
        r_val_q  <= val_mem[ent_raddr[AW-1:0]];
        r_link_q <= link_mem[ent_raddr[AW-1:0]];
        if (r_state == S_CLR) begin
            head_mem[r_clr] <= NIL;
        end
        if (r_state == S_REM1) begin
            if (r_prev >= NIL) begin
                head_mem[r_bkt] <= r_link;
            end else begin
                link_mem[r_prev[AW-1:0]] <= r_link;
            end
        end
        if (r_state == S_REM2) begin
            link_mem[r_idx[AW-1:0]] <= r_free;
        end
        if (r_state == S_INS) begin
            head_mem[r_bkt]         <= r_idx;
            key_mem[r_idx[AW-1:0]]  <= r_key;
            val_mem[r_idx[AW-1:0]]  <= r_val;
            link_mem[r_idx[AW-1:0]] <= r_head;
        end
        if (r_state == S_HIT && r_act == chm_pkg::ACT_UPDATE) begin
            val_mem[r_idx[AW-1:0]] <= r_val;
        end
        if (r_state == S_SW1) begin
            val_mem[r_aidx[AW-1:0]] <= r_fval;
        end
        if (r_state == S_SW2) begin
            val_mem[r_idx[AW-1:0]] <= r_aval;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_free   <= NIL;
            r_nuc    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // DONE reloads the output register itself
            if (r_ovalid && i_ready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == BLAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_act     <= i_item.action;
                        r_key     <= i_item.key;
                        r_key2    <= i_item.second_key;
                        r_val     <= i_item.value;
                        r_dflt    <= i_item.miss_value;
                        r_cur_key <= i_item.key;
                        r_ph      <= 1'b0;
                        r_rem     <= '0;
                        r_mstep   <= '0;
                        r_rv      <= '0;
                        r_st      <= chm_pkg::ST_OK;
                        r_state   <= S_MOD;
                        if (i_item.action == chm_pkg::ACT_SWAP) begin
                            if (i_item.key == '0 && i_item.second_key == '0) begin
                                r_state <= S_DONE;
                            end else if (i_item.key == '0) begin
                                r_act     <= chm_pkg::ACT_REMOVE;
                                r_cur_key <= i_item.second_key;
                            end else if (i_item.second_key == '0) begin
                                r_act <= chm_pkg::ACT_REMOVE;
                            end
                        end else if (i_item.action > chm_pkg::ACT_SWAP) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                // bucket index of r_cur_key
                S_MOD: begin
                    if (POW2) begin
                        r_bkt   <= BW'(r_cur_key & BMASK);
                        r_state <= S_HRD;
                    end else begin
                        r_mstep <= r_mstep + 1'b1;
                        if (r_mstep == 2'd0) begin
                            r_q <= mod_prod[61:31];
                        end else if (r_mstep == 2'd1) begin
                            r_rem <= mod_lo;
                        end else begin
                            r_bkt   <= mod_fix[BW-1:0];
                            r_state <= S_HRD;
                        end
                    end
                end
                S_HRD: begin
                    r_state <= S_HWT;
                end
                // chain head available
                S_HWT: begin
                    r_head <= r_head_q;
                    r_cur  <= r_head_q;
                    r_prev <= NIL;
                    if (r_act == chm_pkg::ACT_INSERT) begin
                        r_state <= S_ALLOC;
                    end else if (r_head_q >= NIL) begin
                        r_state <= S_MISS;
                    end else begin
                        r_state <= S_EWT;
                    end
                end
                // one chain node per cycle
                S_EWT: begin
                    if (r_key_q == r_cur_key) begin
                        r_idx   <= r_cur;
                        r_link  <= r_link_q;
                        r_fval  <= r_val_q;
                        r_state <= S_HIT;
                    end else if (r_link_q >= NIL) begin
                        r_state <= S_MISS;
                    end else begin
                        r_prev <= r_cur;
                        r_cur  <= r_link_q;
                    end
                end
                S_HIT: begin
                    case (r_act)
                        chm_pkg::ACT_FIND: begin
                            r_rv    <= r_fval;
                            r_state <= S_DONE;
                        end
                        chm_pkg::ACT_REMOVE: r_state <= S_REM1;
                        chm_pkg::ACT_SWAP: begin
                            if (!r_ph) begin
                                r_aidx    <= r_idx;
                                r_aval    <= r_fval;
                                r_ph      <= 1'b1;
                                r_cur_key <= r_key2;
                                r_rem     <= '0;
                                r_mstep   <= '0;
                                r_state   <= S_MOD;
                            end else begin
                                r_state <= S_SW1;
                            end
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_MISS: begin
                    case (r_act)
                        chm_pkg::ACT_FIND: begin
                            r_rv    <= r_dflt;
                            r_st    <= chm_pkg::ST_MISSING;
                            r_state <= S_DONE;
                        end
                        chm_pkg::ACT_UPDATE: r_state <= S_ALLOC;
                        default: begin
                            r_st    <= chm_pkg::ST_MISSING;
                            r_state <= S_DONE;
                        end
                    endcase
                end
                // take an entry: free list first, then unused pool
                S_ALLOC: begin
                    if (r_free < NIL) begin
                        r_state <= S_FWT;
                    end else if (r_nuc < NIL) begin
                        r_idx   <= r_nuc;
                        r_nuc   <= r_nuc + 1'b1;
                        r_state <= S_INS;
                    end else begin
                        r_st    <= chm_pkg::ST_FULL;
                        r_state <= S_DONE;
                    end
                end
                S_FWT: begin
                    r_idx   <= r_free;
                    r_free  <= r_link_q;
                    r_state <= S_INS;
                end
                S_INS:  r_state <= S_DONE;
                S_REM1: r_state <= S_REM2;
                S_REM2: begin
                    r_free  <= r_idx;
                    r_state <= S_DONE;
                end
                S_SW1: r_state <= S_SW2;
                S_SW2: r_state <= S_DONE;
                // hand result to output register
                S_DONE: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid          <= 1'b1;
                        r_out.read_value  <= r_rv;
                        r_out.status      <= r_st;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    a_nuc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nuc <= NIL) else $error("pool fill count beyond pool");
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= NIL) else $error("free head out of range");
    a_clr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_ready) else $error("ready during clear");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state != S_IDLE))
        else $error("item accepted but not processed");
    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_ovalid || i_ready)) |=> o_valid)
        else $error("result not loaded");

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`default_nettype none
module tb_top;

    localparam int NBUCKETS = chm_pkg::DEF_BUCKETS;
    localparam int NENTRIES = chm_pkg::DEF_ENTRIES;
    localparam int NIL = NENTRIES;
    localparam int STALL_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    chm_pkg::t_req i_item;
    logic o_valid;
    logic i_ready;
    chm_pkg::t_rsp o_item;

    chained_hash_map_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_item),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_item)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // shadow map state
    int unsigned map_head[NBUCKETS];
    logic [30:0] map_key[NENTRIES];
    logic [31:0] map_val[NENTRIES];
    int unsigned map_link[NENTRIES];
    int unsigned map_free;
    int unsigned map_fresh;

    chm_pkg::t_rsp pending_rsp[$];
    int errors;
    bit idle_on;
    int unsigned quiet_cycles;

    // keys of earlier inserts and updates, drawn again for traffic
    logic [30:0] key_pool[$];

    function automatic int unsigned map_locate(logic [30:0] k, output int unsigned prev);
        int unsigned cur;
        int unsigned steps;
        cur = map_head[k % NBUCKETS];
        prev = NIL;
        steps = 0;
        while (cur < NENTRIES && steps < NENTRIES) begin
            if (map_key[cur] == k)
                return cur;
            prev = cur;
            cur = map_link[cur];
            steps++;
        end
        prev = NIL;
        return NIL;
    endfunction

    function automatic logic [1:0] map_insert(logic [30:0] k, logic [31:0] v);
        int unsigned idx;
        if (map_free < NENTRIES) begin
            idx = map_free;
            map_free = map_link[idx];
        end else if (map_fresh < NENTRIES) begin
            idx = map_fresh;
            map_fresh++;
        end else begin
            return chm_pkg::ST_FULL;
        end
        map_key[idx] = k;
        map_val[idx] = v;
        map_link[idx] = map_head[k % NBUCKETS];
        map_head[k % NBUCKETS] = idx;
        return chm_pkg::ST_OK;
    endfunction

    function automatic logic [1:0] map_remove(logic [30:0] k);
        int unsigned prev;
        int unsigned idx;
        idx = map_locate(k, prev);
        if (idx >= NENTRIES)
            return chm_pkg::ST_MISSING;
        if (prev < NENTRIES)
            map_link[prev] = map_link[idx];
        else
            map_head[k % NBUCKETS] = map_link[idx];
        map_link[idx] = map_free;
        map_free = idx;
        return chm_pkg::ST_OK;
    endfunction

    // expected result of one item, updating the shadow map
    function automatic chm_pkg::t_rsp map_apply(chm_pkg::t_req r);
        chm_pkg::t_rsp res;
        int unsigned p;
        int unsigned a;
        int unsigned b;
        logic [31:0] t;
        res.read_value = '0;
        res.status = chm_pkg::ST_OK;
        case (r.action)
            chm_pkg::ACT_INSERT: res.status = map_insert(r.key, r.value);
            chm_pkg::ACT_FIND: begin
                a = map_locate(r.key, p);
                if (a < NENTRIES) begin
                    res.read_value = map_val[a];
                end else begin
                    res.read_value = r.miss_value;
                    res.status = chm_pkg::ST_MISSING;
                end
            end
            chm_pkg::ACT_REMOVE: res.status = map_remove(r.key);
            chm_pkg::ACT_UPDATE: begin
                a = map_locate(r.key, p);
                if (a < NENTRIES)
                    map_val[a] = r.value;
                else
                    res.status = map_insert(r.key, r.value);
            end
            chm_pkg::ACT_SWAP: begin
                if (r.key == 0 && r.second_key == 0) begin
                    res.status = chm_pkg::ST_OK;
                end else if (r.key == 0) begin
                    res.status = map_remove(r.second_key);
                end else if (r.second_key == 0) begin
                    res.status = map_remove(r.key);
                end else begin
                    a = map_locate(r.key, p);
                    b = map_locate(r.second_key, p);
                    if (a >= NENTRIES || b >= NENTRIES) begin
                        res.status = chm_pkg::ST_MISSING;
                    end else begin
                        t = map_val[a];
                        map_val[a] = map_val[b];
                        map_val[b] = t;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // send one item, with optional idle burst first; valid stays high after
    // acceptance so that back-to-back items need no second drive in one step
    task automatic send_item(chm_pkg::t_req r);
        int gap;
        if (idle_on && $urandom_range(3) == 0) begin
            gap = $urandom_range(1, 5);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= r;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        pending_rsp.push_back(map_apply(r));
    endtask

    function automatic chm_pkg::t_req make_req(logic [2:0] act, logic [30:0] k,
                                               logic [30:0] k2, logic [31:0] v,
                                               logic [31:0] d);
        chm_pkg::t_req r;
        r.action = act;
        r.key = k;
        r.second_key = k2;
        r.value = v;
        r.miss_value = d;
        return r;
    endfunction

    function automatic logic [30:0] rand_key();
        int sel;
        sel = $urandom_range(9);
        if (sel < 6 && key_pool.size() > 0)
            return key_pool[$urandom_range(key_pool.size() - 1)];
        if (sel < 8)
            return 31'($urandom_range(40)) * 31'(NBUCKETS) + 31'($urandom_range(3));
        return 31'($urandom);
    endfunction

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp.size() != 0)
            @(posedge i_clk);
    endtask

    // response checker with random backpressure
    initial begin : rsp_check
        chm_pkg::t_rsp want;
        int hold;
        i_ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (idle_on && $urandom_range(3) == 0) begin
                i_ready <= 1'b0;
                hold = $urandom_range(1, 5);
                repeat (hold) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                if (pending_rsp.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, o_item);
                    errors++;
                end else begin
                    want = pending_rsp.pop_front();
                    if (o_item.read_value !== want.read_value) begin
                        $display("%0t: read_value expected %0d actual %0d",
                                 $time, want.read_value, o_item.read_value);
                        errors++;
                    end
                    if (o_item.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_item.status);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog on accepted items and taken results
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("chained_hash_map_core: mismatch");
            $finish;
        end
    end

    task automatic test_directed();
        send_item(make_req(chm_pkg::ACT_FIND, 31'd0, 31'd0, 32'd0, 32'h8000_0000));
        send_item(make_req(chm_pkg::ACT_REMOVE, 31'd0, 31'd0, 32'd0, 32'd0));
        send_item(make_req(chm_pkg::ACT_INSERT, 31'd0, 31'd0, 32'h7fff_ffff, 32'd0));
        send_item(make_req(chm_pkg::ACT_INSERT, 31'h7fff_ffff, 31'h7fff_ffff,
                           32'h8000_0000, 32'd0));
        send_item(make_req(chm_pkg::ACT_INSERT, 31'd0, 31'd0, 32'd5, 32'd0));
        send_item(make_req(chm_pkg::ACT_FIND, 31'd0, 31'd0, 32'd0, 32'hffff_ffff));
        send_item(make_req(chm_pkg::ACT_INSERT, 31'd256, 31'd0, 32'd77, 32'd0));
        send_item(make_req(chm_pkg::ACT_UPDATE, 31'd256, 31'd0, 32'hdead_beef, 32'd0));
        send_item(make_req(chm_pkg::ACT_UPDATE, 31'd512, 31'd0, 32'd9, 32'd0));
        send_item(make_req(chm_pkg::ACT_SWAP, 31'd256, 31'h7fff_ffff, 32'd0, 32'd0));
        send_item(make_req(chm_pkg::ACT_FIND, 31'h7fff_ffff, 31'd0, 32'd0, 32'd1));
        send_item(make_req(chm_pkg::ACT_SWAP, 31'd256, 31'd256, 32'd0, 32'd0));
        send_item(make_req(chm_pkg::ACT_SWAP, 31'd256, 31'd999, 32'd0, 32'd0));
        send_item(make_req(chm_pkg::ACT_SWAP, 31'd0, 31'd0, 32'd0, 32'd0));
        send_item(make_req(chm_pkg::ACT_SWAP, 31'd0, 31'd512, 32'd0, 32'd0));
        send_item(make_req(chm_pkg::ACT_SWAP, 31'd256, 31'd0, 32'd0, 32'd0));
        send_item(make_req(chm_pkg::ACT_REMOVE, 31'd0, 31'd0, 32'd0, 32'd0));
        send_item(make_req(chm_pkg::ACT_FIND, 31'd0, 31'd0, 32'd0, 32'd3));
        send_item(make_req(3'd5, 31'h7fff_ffff, 31'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff));
        send_item(make_req(3'd6, 31'd1, 31'd2, 32'd3, 32'd4));
        send_item(make_req(3'd7, 31'd0, 31'd0, 32'd0, 32'd0));
    endtask

    task automatic test_random(int count);
        chm_pkg::t_req r;
        int sel;
        repeat (count) begin
            sel = $urandom_range(99);
            r = make_req(chm_pkg::ACT_FIND, rand_key(), rand_key(), $urandom, $urandom);
            if (sel < 30) r.action = chm_pkg::ACT_INSERT;
            else if (sel < 50) r.action = chm_pkg::ACT_FIND;
            else if (sel < 65) r.action = chm_pkg::ACT_REMOVE;
            else if (sel < 80) r.action = chm_pkg::ACT_UPDATE;
            else if (sel < 96) r.action = chm_pkg::ACT_SWAP;
            else r.action = 3'($urandom_range(5, 7));
            if (r.action == chm_pkg::ACT_SWAP && $urandom_range(7) == 0) r.key = '0;
            if (r.action == chm_pkg::ACT_SWAP && $urandom_range(7) == 0) r.second_key = '0;
            if (r.action == chm_pkg::ACT_INSERT || r.action == chm_pkg::ACT_UPDATE)
                key_pool.push_back(r.key);
            send_item(r);
        end
    endtask

    // fill the pool past its end, then drain part of it
    task automatic test_pool_full();
        chm_pkg::t_req r;
        while (map_fresh < NENTRIES || map_free < NENTRIES) begin
            r = make_req(chm_pkg::ACT_INSERT, 31'($urandom_range(300)), 31'd0, $urandom, 32'd0);
            key_pool.push_back(r.key);
            send_item(r);
        end
        send_item(make_req(chm_pkg::ACT_INSERT, 31'd4, 31'd0, 32'd1, 32'd0));
        send_item(make_req(chm_pkg::ACT_UPDATE, 31'h7fff_fff0, 31'd0, 32'd1, 32'd0));
        send_item(make_req(chm_pkg::ACT_UPDATE, key_pool[0], 31'd0, 32'd2, 32'd0));
        repeat (40) send_item(make_req(chm_pkg::ACT_REMOVE, 31'($urandom_range(300)),
                                       31'd0, 32'd0, 32'd0));
    endtask

    initial begin
        errors = 0;
        idle_on = 1'b1;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_item <= '0;
        foreach (map_head[i]) map_head[i] = NIL;
        map_free = NIL;
        map_fresh = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        // hold off until all results are back
        wait_drained();
        test_random(50);
        test_pool_full();
        idle_on = 1'b0;
        test_random(50);
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("chained_hash_map_core: match");
        else
            $display("chained_hash_map_core: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
